// File: rtl/core/cold_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cold_pkg
// Codes, masks and helper functions for the opcode legality decoder.
// ----------------------------------------------------------------------------
package cold_pkg;

    // Instruction kinds.
    typedef logic [3:0] t_kind;
    localparam t_kind KIND_NONE        = 4'd0;
    localparam t_kind KIND_ORI         = 4'd1;
    localparam t_kind KIND_ANDI        = 4'd2;
    localparam t_kind KIND_SUBI        = 4'd3;
    localparam t_kind KIND_ADDI        = 4'd4;
    localparam t_kind KIND_EORI        = 4'd5;
    localparam t_kind KIND_MOVE        = 4'd6;
    localparam t_kind KIND_MOVE_FROM_SR = 4'd7;
    localparam t_kind KIND_MOVE_TO_CCR = 4'd8;
    localparam t_kind KIND_MOVE_TO_SR  = 4'd9;

    // Operand sizes.
    typedef logic [1:0] t_size;
    localparam t_size SIZE_BYTE = 2'd0;
    localparam t_size SIZE_WORD = 2'd1;
    localparam t_size SIZE_LONG = 2'd2;
    localparam t_size SIZE_BAD  = 2'd3;

    // Addressing modes.
    typedef logic [3:0] t_mode;
    localparam t_mode MODE_DN      = 4'd0;
    localparam t_mode MODE_AN      = 4'd1;
    localparam t_mode MODE_AN_IND  = 4'd2;
    localparam t_mode MODE_AN_POST = 4'd3;
    localparam t_mode MODE_AN_PRE  = 4'd4;
    localparam t_mode MODE_AN_D16  = 4'd5;
    localparam t_mode MODE_AN_IDX  = 4'd6;
    localparam t_mode MODE_ABS_W   = 4'd7;
    localparam t_mode MODE_ABS_L   = 4'd8;
    localparam t_mode MODE_PC_D16  = 4'd9;
    localparam t_mode MODE_PC_IDX  = 4'd10;
    localparam t_mode MODE_IMM     = 4'd11;
    localparam t_mode MODE_NONE    = 4'd12;

    // Opcode masks and patterns.
    localparam logic [15:0] MASK_MOVE_GROUP = 16'hC000;
    localparam logic [15:0] MASK_MOVE_SIZE  = 16'h3000;
    localparam logic [15:0] MASK_SR_OP      = 16'hFFC0;
    localparam logic [15:0] PAT_MOVE_FROM_SR = 16'h40C0;
    localparam logic [15:0] MASK_TO_SR_CCR  = 16'hFDC0;
    localparam logic [15:0] PAT_MOVE_TO_CCR = 16'h44C0;
    localparam logic [15:0] MASK_IMM_HI     = 16'hFF00;
    localparam logic [15:0] PAT_ORI         = 16'h0000;
    localparam logic [15:0] PAT_ANDI        = 16'h0200;
    localparam logic [15:0] PAT_SUBI        = 16'h0400;
    localparam logic [15:0] PAT_ADDI        = 16'h0600;
    localparam logic [15:0] PAT_EORI        = 16'h0A00;

    // Result item width, packed into whole bytes.
    localparam int RESULT_BITS = 29;
    localparam int OUT_DATA_W  = 32;
    localparam int IN_DATA_W   = 16;

    // Mode of a six-bit effective address field (mode in bits 5..3).
    function automatic t_mode mode_of(input logic [5:0] six);
        logic [2:0] m;
        logic [2:0] r;
        m = six[5:3];
        r = six[2:0];
        if (m != 3'd7) begin
            mode_of = {1'b0, m};
        end else if (r <= 3'd4) begin
            mode_of = MODE_ABS_W + {1'b0, r};
        end else begin
            mode_of = MODE_NONE;
        end
    endfunction

    // Extension words that follow for an addressing mode.
    function automatic logic [1:0] ext_words(input t_mode mode, input t_size size);
        case (mode)
            MODE_AN_D16, MODE_AN_IDX, MODE_ABS_W,
            MODE_PC_D16, MODE_PC_IDX: ext_words = 2'd1;
            MODE_ABS_L:               ext_words = 2'd2;
            MODE_IMM:                 ext_words = (size == SIZE_LONG) ? 2'd2 : 2'd1;
            default:                  ext_words = 2'd0;
        endcase
    endfunction

    // The mode addresses memory.
    function automatic logic is_memory(input t_mode mode);
        is_memory = (mode != MODE_DN) && (mode != MODE_AN) &&
                    (mode != MODE_IMM) && (mode != MODE_NONE);
    endfunction

    // Size field of a MOVE opcode, bits 13..12.
    function automatic t_size move_size(input logic [1:0] code);
        case (code)
            2'd1:    move_size = SIZE_BYTE;
            2'd2:    move_size = SIZE_LONG;
            2'd3:    move_size = SIZE_WORD;
            default: move_size = SIZE_BAD;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/cpu_opcode_legality_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_opcode_legality_decoder_unit
// Decodes one 16-bit opcode of a 68000-style instruction subset per item.
// ----------------------------------------------------------------------------
// The unit takes one opcode item per cycle while the receiver takes results and
// returns one decoded result item for each: the opcode is captured in an input
// register, decoded by shallow combinational logic, and the result lands in an
// output register. The two registers advance together whenever the output
// register is empty or being taken, so throughput is one item per cycle and the
// input side keeps accepting into an empty input register while a result waits.
// Illegal opcodes give a result item with every field zero.
module cpu_opcode_legality_decoder_unit
    import cold_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // Opcode items.
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // Fields from bit 0: opcode_word[15:0].
    input  wire  [IN_DATA_W-1:0]  i_s_axis_tdata,
    // Decoded result items.
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // Fields from bit 0: legal[0], kind[4:1], size[6:5], ea_kind[10:7],
    // ea_register[13:11], dest_kind[17:14], dest_register[20:18],
    // imm_words[22:21], ea_ext_words[24:23], dest_ext_words[26:25],
    // align_check[27], writes_memory[28], zero fill[31:29].
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic                   r_in_valid;
    logic [IN_DATA_W-1:0]   r_in_op;
    logic                   r_out_valid;
    logic [RESULT_BITS-1:0] r_out_data;
    logic [RESULT_BITS-1:0] n_out_data;
    logic                   advance;

    // Both stages move when the output register can take a new item.
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-RESULT_BITS){1'b0}}, r_out_data};

    // Decode of the registered opcode.
    always_comb begin
        logic [15:0] op;
        t_mode       src;
        t_mode       dm;
        t_kind       kind;
        t_kind       k;
        t_size       size;
        t_mode       dmode;
        logic [2:0]  dreg;
        logic [1:0]  imm;
        logic [1:0]  dext;
        logic        wmem;
        logic        ok;
        op    = r_in_op;
        src   = mode_of(op[5:0]);
        dm    = mode_of({op[8:6], op[11:9]});
        kind  = KIND_NONE;
        k     = KIND_NONE;
        size  = SIZE_BYTE;
        dmode = MODE_DN;
        dreg  = 3'd0;
        imm   = 2'd0;
        dext  = 2'd0;
        wmem  = 1'b0;
        ok    = 1'b0;
        if ((op & MASK_MOVE_GROUP) == 16'h0000 && (op & MASK_MOVE_SIZE) != 16'h0000) begin
            // MOVE and MOVEA.
            size = move_size(op[13:12]);
            if (dm <= MODE_ABS_L && src != MODE_NONE &&
                !(size == SIZE_BYTE && (src == MODE_AN || dm == MODE_AN))) begin
                ok    = 1'b1;
                kind  = KIND_MOVE;
                dmode = dm;
                dreg  = op[11:9];
                dext  = ext_words(dm, size);
                wmem  = dm >= MODE_AN_IND;
            end
        end else if ((op & MASK_SR_OP) == PAT_MOVE_FROM_SR) begin
            // MOVE from SR.
            size = SIZE_WORD;
            if (src != MODE_AN && src <= MODE_ABS_L) begin
                ok   = 1'b1;
                kind = KIND_MOVE_FROM_SR;
                wmem = src >= MODE_AN_IND;
            end
        end else if ((op & MASK_TO_SR_CCR) == PAT_MOVE_TO_CCR) begin
            // MOVE to CCR or SR.
            size = SIZE_WORD;
            if (src != MODE_AN && src != MODE_NONE) begin
                ok   = 1'b1;
                kind = op[9] ? KIND_MOVE_TO_SR : KIND_MOVE_TO_CCR;
            end
        end else begin
            // Immediate group.
            case (op & MASK_IMM_HI)
                PAT_ORI:  k = KIND_ORI;
                PAT_ANDI: k = KIND_ANDI;
                PAT_SUBI: k = KIND_SUBI;
                PAT_ADDI: k = KIND_ADDI;
                PAT_EORI: k = KIND_EORI;
                default:  k = KIND_NONE;
            endcase
            size = op[7:6];
            if (k != KIND_NONE && size != SIZE_BAD && src != MODE_AN && src <= MODE_ABS_L) begin
                ok   = 1'b1;
                kind = k;
                imm  = (size == SIZE_LONG) ? 2'd2 : 2'd1;
                wmem = src >= MODE_AN_IND;
            end
        end
        if (ok) begin
            n_out_data = {wmem,
                          is_memory(src) && (size != SIZE_BYTE),
                          dext,
                          ext_words(src, size),
                          imm,
                          dreg,
                          dmode,
                          op[2:0],
                          src,
                          size,
                          kind,
                          1'b1};
        end else begin
            n_out_data = '0;
        end
    end

    // Valid flags of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op <= i_s_axis_tdata;
        end
        if (advance && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
`default_nettype wire

// File: dv/cpu_opcode_legality_decoder_unit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_opcode_legality_decoder_unit_test
// Self-checking bench for the opcode legality decoder.
// ----------------------------------------------------------------------------
// Opcode items are streamed into the unit and every accepted item is decoded
// by an independent model in this bench. The decoded result is queued and each
// result item leaving the unit is checked field by field against the oldest
// entry. A directed set covers every instruction kind and the illegal corner
// forms. Random streams then follow, mostly well-formed encodings with random
// operand fields and some raw words, with random gaps on both sides. A long
// receiver hold-off fills the unit, and the sender drains it at times.
module cpu_opcode_legality_decoder_unit_test;
    import cold_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int HOLD_CYCLES  = 60;
    localparam int LIMIT_CYCLES = 400000;

    // Decoded result item, laid out as on o_m_axis_tdata (first member on top).
    typedef struct packed {
        logic [2:0] fill;
        logic       writes_memory;
        logic       align_check;
        logic [1:0] dest_ext_words;
        logic [1:0] ea_ext_words;
        logic [1:0] imm_words;
        logic [2:0] dest_register;
        t_mode      dest_kind;
        logic [2:0] ea_register;
        t_mode      ea_kind;
        t_size      size;
        t_kind      kind;
        logic       legal;
    } t_decoded;

    typedef struct {
        logic [15:0] opcode;
        t_decoded    decoded;
    } t_pending;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    t_pending pending_q[$];
    int       err_count = 0;
    bit       idling = 1'b1;
    bit       hold_req = 1'b0;

    cpu_opcode_legality_decoder_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Clock generation.
    initial begin
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    // Addressing mode of a six-bit effective address field.
    function automatic t_mode addr_mode(input logic [5:0] ea);
        if (ea[5:3] != 3'd7) begin
            return t_mode'({1'b0, ea[5:3]});
        end
        if (ea[2:0] <= 3'd4) begin
            return t_mode'(MODE_ABS_W + ea[2:0]);
        end
        return MODE_NONE;
    endfunction

    // Count of extension words that an addressing mode pulls in.
    function automatic logic [1:0] ext_count(input t_mode m, input t_size sz);
        case (m)
            MODE_AN_D16, MODE_AN_IDX, MODE_ABS_W, MODE_PC_D16, MODE_PC_IDX: begin
                return 2'd1;
            end
            MODE_ABS_L: begin
                return 2'd2;
            end
            MODE_IMM: begin
                return (sz == SIZE_LONG) ? 2'd2 : 2'd1;
            end
            default: begin
                return 2'd0;
            end
        endcase
    endfunction

    // Full decode of one opcode word into the expected result item.
    function automatic t_decoded decode_opcode(input logic [15:0] op);
        t_decoded res;
        t_mode    src;
        t_mode    dst;
        t_size    sz;
        t_kind    k;
        logic     ok;
        res = '0;
        src = addr_mode(op[5:0]);
        sz = SIZE_BYTE;
        k = KIND_NONE;
        ok = 1'b0;
        if (op[15:14] == 2'b00 && op[13:12] != 2'b00) begin
            // MOVE: destination register in bits 11..9, its mode in 8..6.
            dst = addr_mode({op[8:6], op[11:9]});
            case (op[13:12])
                2'b01:   sz = SIZE_BYTE;
                2'b10:   sz = SIZE_LONG;
                default: sz = SIZE_WORD;
            endcase
            // No byte moves to or from an address register.
            if (dst <= MODE_ABS_L && src != MODE_NONE &&
                !(sz == SIZE_BYTE && (src == MODE_AN || dst == MODE_AN))) begin
                ok = 1'b1;
                k = KIND_MOVE;
                res.dest_kind = dst;
                res.dest_register = op[11:9];
                res.dest_ext_words = ext_count(dst, sz);
                res.writes_memory = (dst >= MODE_AN_IND);
            end
        end else if ((op & MASK_SR_OP) == PAT_MOVE_FROM_SR) begin
            sz = SIZE_WORD;
            if (src != MODE_AN && src <= MODE_ABS_L) begin
                ok = 1'b1;
                k = KIND_MOVE_FROM_SR;
                res.writes_memory = (src >= MODE_AN_IND);
            end
        end else if ((op & MASK_TO_SR_CCR) == PAT_MOVE_TO_CCR) begin
            sz = SIZE_WORD;
            if (src != MODE_AN && src != MODE_NONE) begin
                ok = 1'b1;
                k = op[9] ? KIND_MOVE_TO_SR : KIND_MOVE_TO_CCR;
            end
        end else begin
            // Immediate group; the immediate destination form (to CCR/SR) is
            // outside the subset and falls out through the mode check.
            case (op & MASK_IMM_HI)
                PAT_ORI:  k = KIND_ORI;
                PAT_ANDI: k = KIND_ANDI;
                PAT_SUBI: k = KIND_SUBI;
                PAT_ADDI: k = KIND_ADDI;
                PAT_EORI: k = KIND_EORI;
                default:  k = KIND_NONE;
            endcase
            sz = t_size'(op[7:6]);
            if (k != KIND_NONE && sz != SIZE_BAD && src != MODE_AN &&
                src <= MODE_ABS_L) begin
                ok = 1'b1;
                res.imm_words = (sz == SIZE_LONG) ? 2'd2 : 2'd1;
                res.writes_memory = (src >= MODE_AN_IND);
            end
        end
        if (!ok) begin
            return '0;
        end
        res.legal = 1'b1;
        res.kind = k;
        res.size = sz;
        res.ea_kind = src;
        res.ea_register = op[2:0];
        res.ea_ext_words = ext_count(src, sz);
        res.align_check = (src >= MODE_AN_IND && src <= MODE_PC_IDX && sz != SIZE_BYTE);
        return res;
    endfunction

    // Random gap length: mostly none, some short, a few long.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (!idling || pick < 60) begin
            return 0;
        end
        if (pick < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Opcode of a random instruction form with random operand fields.
    function automatic logic [15:0] random_opcode();
        logic [15:0] op;
        logic [5:0]  ea;
        ea = 6'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                op = {2'b00, 2'($urandom_range(1, 3)), 6'($urandom), ea};
            end
            3: begin
                op = PAT_MOVE_FROM_SR | {10'd0, ea};
            end
            4: begin
                op = PAT_MOVE_TO_CCR | {6'd0, 1'($urandom), 3'd0, ea};
            end
            5, 6: begin
                case ($urandom_range(0, 4))
                    0:       op = PAT_ORI;
                    1:       op = PAT_ANDI;
                    2:       op = PAT_SUBI;
                    3:       op = PAT_ADDI;
                    default: op = PAT_EORI;
                endcase
                op = op | {8'd0, 2'($urandom), ea};
            end
            default: begin
                op = 16'($urandom);
            end
        endcase
        return op;
    endfunction

    // Offer one opcode item and wait until the unit takes it.
    task automatic send_opcode(input logic [15:0] op);
        int n;
        n = gap_len();
        if (n > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= op;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
    endtask

    // Stop offering and wait until every queued result has come back. The
    // first edge lets the monitor record an item taken at the current edge.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_q.size() != 0);
    endtask

    task automatic check_field(input string name, input int exp_val, input int got_val,
                               input logic [15:0] op);
        if (exp_val !== got_val) begin
            $display("%0t: opcode %h %s expected %0d, actual %0d",
                     $time, op, name, exp_val, got_val);
            err_count++;
        end
    endtask

    // Item monitor: record accepted opcodes, then check accepted results.
    always @(posedge i_clk) begin
        t_pending head;
        t_decoded got;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                head.opcode = i_s_axis_tdata;
                head.decoded = decode_opcode(i_s_axis_tdata);
                pending_q.push_back(head);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_decoded'(o_m_axis_tdata);
                if (pending_q.size() == 0) begin
                    $display("%0t: result item %h with no opcode outstanding",
                             $time, o_m_axis_tdata);
                    err_count++;
                end else begin
                    head = pending_q.pop_front();
                    check_field("legal", head.decoded.legal, got.legal, head.opcode);
                    check_field("kind", head.decoded.kind, got.kind, head.opcode);
                    check_field("size", head.decoded.size, got.size, head.opcode);
                    check_field("ea_kind", head.decoded.ea_kind, got.ea_kind, head.opcode);
                    check_field("ea_register", head.decoded.ea_register,
                                got.ea_register, head.opcode);
                    check_field("dest_kind", head.decoded.dest_kind, got.dest_kind,
                                head.opcode);
                    check_field("dest_register", head.decoded.dest_register,
                                got.dest_register, head.opcode);
                    check_field("imm_words", head.decoded.imm_words, got.imm_words,
                                head.opcode);
                    check_field("ea_ext_words", head.decoded.ea_ext_words,
                                got.ea_ext_words, head.opcode);
                    check_field("dest_ext_words", head.decoded.dest_ext_words,
                                got.dest_ext_words, head.opcode);
                    check_field("align_check", head.decoded.align_check,
                                got.align_check, head.opcode);
                    check_field("writes_memory", head.decoded.writes_memory,
                                got.writes_memory, head.opcode);
                    check_field("fill", 0, got.fill, head.opcode);
                end
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = gap_len();
                if (n > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_m_axis_tready <= 1'b1;
        end
    end

    // Every kind, each illegal corner form and the word extremes.
    task automatic test_directed();
        logic [15:0] words[$];
        words = '{
            16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
            16'h0250, 16'h04B9, 16'h0669, 16'h0A27, // andi, subi, addi, eori
            16'h003C, 16'h027C, 16'h0A7C,           // immediate to ccr or sr
            16'h0048, 16'h00C0, 16'h003A, 16'h0800, // An, bad size, pc, other
            16'h1000, 16'h1008, 16'h1040,           // byte move, byte to/from An
            16'h3048, 16'h2049, 16'h23FC, 16'h35BA, // movea, imm to abs.L, pc d16
            16'h35C0, 16'h303D,                     // bad dest mode, bad src mode
            16'h40C0, 16'h40C8, 16'h40FC, 16'h40F9, // move from sr
            16'h44FC, 16'h46DB, 16'h46C8, 16'h4E71  // move to ccr or sr, other
        };
        idling = 1'b1;
        foreach (words[i]) begin
            send_opcode(words[i]);
        end
        drain_results();
    endtask

    // Back-to-back items with both sides always ready.
    task automatic test_full_rate();
        idling = 1'b0;
        repeat (100) begin
            send_opcode(random_opcode());
        end
        drain_results();
        idling = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering; the unit must fill.
    task automatic test_backpressure();
        idling = 1'b0;
        hold_req = 1'b1;
        repeat (16) begin
            send_opcode(random_opcode());
        end
        drain_results();
        idling = 1'b1;
    endtask

    // Random stream with random gaps, pausing now and then until empty.
    task automatic test_random_stream();
        idling = 1'b1;
        for (int i = 0; i < 360; i++) begin
            send_opcode(random_opcode());
            if ($urandom_range(0, 59) == 0) begin
                drain_results();
            end
        end
        drain_results();
    endtask

    // Test sequence.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_rate();
        test_backpressure();
        test_random_stream();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
